FILE: src/msbm_pkg.sv
// shared types and codes of the multiple stack bank mover
`default_nettype none

package msbm_pkg;

    // operation codes carried in func
    typedef enum logic [1:0] {
        FN_PUSH = 2'd0,
        FN_MOVE = 2'd1,
        FN_READ = 2'd2,
        FN_NONE = 2'd3
    } func_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_LOAD_A   = 9'b000000010,
        S_LOAD_B   = 9'b000000100,
        S_EXEC     = 9'b000001000,
        S_STORE_A  = 9'b000010000,
        S_STORE_B  = 9'b000100000,
        S_TOP_RD   = 9'b001000000,
        S_TOP_WAIT = 9'b010000000,
        S_SPARE    = 9'b100000000
    } state_t;

endpackage

`default_nettype wire

FILE: src/multi_stack_bank_mover_core.sv
// top level of the multiple stack bank mover: sequencer, item memory and fill counts
`default_nettype none

// A bank of NUM_STACKS byte stacks, STACK_DEPTH deep each, sharing one
// synchronous item memory (one write port, one read port, registered
// read); the per-stack fill counts and the count of stacks in use sit in
// flip-flops that reset clears. The item memory has no reset and needs no
// clearing pass: only entries below a stack's fill count are ever read. Each
// accepted word gives exactly one result word. The sequencer steps through
// load A, load B, exec, store A, store B, top read and top wait, staying in
// exec while a move transfers bytes; top wait hands the result to the output
// register once it is free. The transfer loop reads the source top and writes
// the previous byte to the destination in the same cycle, so the memory's
// single read port sets the pace of one byte per cycle. A new word is
// accepted as soon as the sequencer is back in idle, even while the previous
// result still waits in the output register. Stack numbers at or above
// NUM_STACKS act as stacks that are both empty and of zero capacity.
module multi_stack_bank_mover_core #(
    parameter int NUM_STACKS  = 16,
    parameter int STACK_DEPTH = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] func,
    input  wire logic [3:0] stack_a,
    input  wire logic [3:0] stack_b,
    input  wire logic [6:0] amount,
    input  wire logic [7:0] item_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      top_byte,
    output logic            stack_empty,
    output logic [1:0]      status,
    output logic [4:0]      stacks_used
);

    // widths derived from the bank shape
    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(NUM_STACKS * STACK_DEPTH);
    localparam int NS_LIM = (NUM_STACKS > 16) ? 16 : NUM_STACKS;
    localparam logic [FW-1:0] DEPTH_F = FW'(STACK_DEPTH);
    localparam logic [AW-1:0] DEPTH_A = AW'(STACK_DEPTH);

    // sequencer and latched word
    msbm_pkg::state_t  state_reg, state_next;
    msbm_pkg::func_t   func_reg, func_next;
    logic [3:0]        sa_reg, sa_next;
    logic [3:0]        sb_reg, sb_next;
    logic [6:0]        rem_reg, rem_next;
    logic [7:0]        byte_reg, byte_next;
    logic              ex_a_reg, ex_a_next;
    logic              ex_b_reg, ex_b_next;
    logic [AW-1:0]     base_a_reg, base_a_next;
    logic [AW-1:0]     base_b_reg, base_b_next;

    // working copies of the two fill counts
    logic [FW-1:0]     fa_reg, fa_next;
    logic [FW-1:0]     fb_reg, fb_next;

    msbm_pkg::status_t status_reg, status_next;
    logic [4:0]        used_reg, used_next;
    logic              top_empty_reg, top_empty_next;

    // byte read in the previous cycle waiting to be written to the destination
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;

    // output register
    logic              out_valid_reg;
    logic [7:0]        top_byte_reg;
    logic              stack_empty_reg;
    msbm_pkg::status_t out_status_reg;
    logic [4:0]        out_used_reg;
    logic              out_load;

    // per-stack fill counts
    logic [FW-1:0]     fill_reg [NUM_STACKS];
    logic              fill_we;
    logic [SW-1:0]     fill_widx;
    logic [FW-1:0]     fill_wdata;
    logic [SW-1:0]     ld_idx;
    logic [FW-1:0]     ld_fill;

    // item memory
    logic [7:0]        item_mem [NUM_STACKS * STACK_DEPTH];
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [7:0]        mem_rdata_reg;

    // derived conditions
    logic [SW-1:0]     ia, ib;
    logic              same_stack;
    logic              empty_a, full_a, full_b;
    logic              in_fire;
    logic              shown_b;
    logic              shown_empty;
    logic [FW-1:0]     shown_fill;
    logic [AW-1:0]     shown_base;
    logic [4:0]        push_used;

    assign ia         = SW'(sa_reg);
    assign ib         = SW'(sb_reg);
    assign same_stack = (sa_reg == sb_reg);
    assign empty_a    = !ex_a_reg || (fa_reg == '0);
    assign full_a     = !ex_a_reg || (fa_reg == DEPTH_F);
    assign full_b     = !ex_b_reg || (fb_reg == DEPTH_F);
    assign push_used  = {1'b0, sa_reg} + 5'd1;

    // a move reports its destination, everything else its first stack
    assign shown_b     = (func_reg == msbm_pkg::FN_MOVE);
    assign shown_fill  = shown_b ? fb_reg : fa_reg;
    assign shown_base  = shown_b ? base_b_reg : base_a_reg;
    assign shown_empty = shown_b ? (!ex_b_reg || (fb_reg == '0)) : empty_a;

    assign in_ready = (state_reg == msbm_pkg::S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == msbm_pkg::S_TOP_WAIT) && (!out_valid_reg || out_ready);

    // fill count read port, one address per cycle
    assign ld_idx  = (state_reg == msbm_pkg::S_LOAD_A) ? ia : ib;
    assign ld_fill = fill_reg[ld_idx];

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        rem_next       = rem_reg;
        byte_next      = byte_reg;
        ex_a_next      = ex_a_reg;
        ex_b_next      = ex_b_reg;
        base_a_next    = base_a_reg;
        base_b_next    = base_b_reg;
        fa_next        = fa_reg;
        fb_next        = fb_reg;
        status_next    = status_reg;
        used_next      = used_reg;
        top_empty_next = top_empty_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        fill_we        = 1'b0;
        fill_widx      = ia;
        fill_wdata     = fa_reg;
        mem_re         = 1'b0;
        mem_raddr      = base_a_reg + AW'(fa_reg) - AW'(1);

        // the byte fetched last cycle lands on the destination top
        mem_we    = pend_reg;
        mem_waddr = pend_addr_reg;
        mem_wdata = mem_rdata_reg;

        case (state_reg)
            msbm_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    func_next   = msbm_pkg::func_t'(func);
                    sa_next     = stack_a;
                    sb_next     = stack_b;
                    rem_next    = amount;
                    byte_next   = item_byte;
                    ex_a_next   = ({1'b0, stack_a} < 5'(NS_LIM));
                    ex_b_next   = ({1'b0, stack_b} < 5'(NS_LIM));
                    base_a_next = AW'(SW'(stack_a)) * DEPTH_A;
                    base_b_next = AW'(SW'(stack_b)) * DEPTH_A;
                    status_next = msbm_pkg::ST_OK;
                    state_next  = msbm_pkg::S_LOAD_A;
                end
            end

            msbm_pkg::S_LOAD_A:
            begin
                fa_next    = ex_a_reg ? ld_fill : '0;
                state_next = msbm_pkg::S_LOAD_B;
            end

            msbm_pkg::S_LOAD_B:
            begin
                fb_next    = ex_b_reg ? ld_fill : '0;
                state_next = msbm_pkg::S_EXEC;
            end

            msbm_pkg::S_EXEC:
            begin
                case (func_reg)
                    msbm_pkg::FN_PUSH:
                    begin
                        if (full_a)
                        begin
                            status_next = msbm_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = base_a_reg + AW'(fa_reg);
                            mem_wdata = byte_reg;
                            fa_next   = fa_reg + FW'(1);
                            if (push_used > used_reg)
                            begin
                                used_next = push_used;
                            end
                        end
                        state_next = msbm_pkg::S_STORE_A;
                    end

                    msbm_pkg::FN_MOVE:
                    begin
                        if (same_stack)
                        begin
                            // popping and pushing the same top leaves the stack as is
                            if ((rem_reg != '0) && empty_a)
                            begin
                                status_next = msbm_pkg::ST_EMPTY;
                            end
                            state_next = msbm_pkg::S_STORE_A;
                        end
                        else if (rem_reg == '0)
                        begin
                            state_next = msbm_pkg::S_STORE_A;
                        end
                        else if (empty_a)
                        begin
                            status_next = msbm_pkg::ST_EMPTY;
                            state_next  = msbm_pkg::S_STORE_A;
                        end
                        else if (full_b)
                        begin
                            status_next = msbm_pkg::ST_FULL;
                            state_next  = msbm_pkg::S_STORE_A;
                        end
                        else
                        begin
                            // fetch the source top now, write it next cycle
                            mem_re         = 1'b1;
                            mem_raddr      = base_a_reg + AW'(fa_reg) - AW'(1);
                            pend_next      = 1'b1;
                            pend_addr_next = base_b_reg + AW'(fb_reg);
                            fa_next        = fa_reg - FW'(1);
                            fb_next        = fb_reg + FW'(1);
                            rem_next       = rem_reg - 7'd1;
                        end
                    end

                    default:
                    begin
                        state_next = msbm_pkg::S_STORE_A;
                    end
                endcase
            end

            msbm_pkg::S_STORE_A:
            begin
                fill_we    = ex_a_reg;
                fill_widx  = ia;
                fill_wdata = fa_reg;
                state_next = msbm_pkg::S_STORE_B;
            end

            msbm_pkg::S_STORE_B:
            begin
                fill_we    = ex_b_reg && (func_reg == msbm_pkg::FN_MOVE) && !same_stack;
                fill_widx  = ib;
                fill_wdata = fb_reg;
                state_next = msbm_pkg::S_TOP_RD;
            end

            msbm_pkg::S_TOP_RD:
            begin
                mem_re         = !shown_empty;
                mem_raddr      = shown_base + AW'(shown_fill) - AW'(1);
                top_empty_next = shown_empty;
                state_next     = msbm_pkg::S_TOP_WAIT;
            end

            msbm_pkg::S_TOP_WAIT:
            begin
                if (out_load)
                begin
                    state_next = msbm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = msbm_pkg::S_IDLE;
            end
        endcase
    end

    // control and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= msbm_pkg::S_IDLE;
            used_reg   <= '0;
            pend_reg   <= 1'b0;
            status_reg <= msbm_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            pend_reg   <= pend_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        sa_reg        <= sa_next;
        sb_reg        <= sb_next;
        rem_reg       <= rem_next;
        byte_reg      <= byte_next;
        ex_a_reg      <= ex_a_next;
        ex_b_reg      <= ex_b_next;
        base_a_reg    <= base_a_next;
        base_b_reg    <= base_b_next;
        fa_reg        <= fa_next;
        fb_reg        <= fb_next;
        top_empty_reg <= top_empty_next;
        pend_addr_reg <= pend_addr_next;
    end

    // fill counts, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (fill_we)
        begin
            fill_reg[fill_widx] <= fill_wdata;
        end
    end

    // item memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            item_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= item_mem[mem_raddr];
        end
    end

    // output register, frees the sequencer while a result waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            top_byte_reg    <= top_empty_reg ? 8'd0 : mem_rdata_reg;
            stack_empty_reg <= top_empty_reg;
            out_status_reg  <= status_reg;
            out_used_reg    <= used_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign top_byte    = top_byte_reg;
    assign stack_empty = stack_empty_reg;
    assign status      = out_status_reg;
    assign stacks_used = out_used_reg;

    // working fill counts never pass the stack depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != msbm_pkg::S_IDLE && state_reg != msbm_pkg::S_LOAD_A
            && state_reg != msbm_pkg::S_LOAD_B) |-> (fa_reg <= DEPTH_F && fb_reg <= DEPTH_F))
    else $error("working fill count above stack depth");

    // a pending transfer write only follows a move step of two distinct stacks
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (func_reg == msbm_pkg::FN_MOVE && !same_stack
            && (state_reg == msbm_pkg::S_EXEC || state_reg == msbm_pkg::S_STORE_A)))
    else $error("transfer write outside a move");

    // the count of stacks in use never falls
    assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (used_reg >= $past(used_reg)))
    else $error("stacks in use decreased");

    // a reported result never carries the reserved status code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_status_reg != msbm_pkg::ST_RSVD))
    else $error("reserved status code reported");

endmodule

`default_nettype wire

FILE: sim/multi_stack_bank_mover_core_tb.sv
// self-checking testbench of the multiple stack bank mover core
`timescale 1ns / 1ps

module multi_stack_bank_mover_core_tb;

    localparam int NUM_STACKS  = 16;
    localparam int STACK_DEPTH = 64;
    // slowest correct run is around 850 words
    localparam int CYCLE_LIMIT = 600000;
    // the tail wait is long enough to cover a move of 64 bytes
    localparam int TAIL_CYCLES = 100;

    // one result word as the block should report it
    typedef struct packed {
        logic [7:0]        top;
        logic              empty;
        msbm_pkg::status_t st;
        logic [4:0]        used;
    } bank_result_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] func;
    logic [3:0] stack_a;
    logic [3:0] stack_b;
    logic [6:0] amount;
    logic [7:0] item_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] top_byte;
    logic       stack_empty;
    logic [1:0] status;
    logic [4:0] stacks_used;

    // predicted contents of the bank, updated as each word is accepted
    logic [7:0]  bank_mem [NUM_STACKS][STACK_DEPTH];
    int unsigned bank_fill [NUM_STACKS];
    int unsigned bank_used;

    // results still owed by the block, oldest first
    bank_result_t pending_results[$];
    bank_result_t want;

    // sender burst control and receiver stall pattern
    int  burst_left  = 0;
    bit  allow_gaps  = 1'b1;
    bit  rx_always   = 1'b0;
    int  rx_cycle    = 0;
    int  rx_style    = 0;
    int  hot_base    = 0;

    // run bookkeeping
    int  cycle_count    = 0;
    int  words_sent     = 0;
    int  results_seen   = 0;
    int  mismatch_count = 0;
    int  push_count     = 0;
    int  move_count     = 0;
    int  read_count     = 0;
    int  empty_faults   = 0;
    int  full_faults    = 0;

    multi_stack_bank_mover_core #(
        .NUM_STACKS (NUM_STACKS),
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .stack_a    (stack_a),
        .stack_b    (stack_b),
        .amount     (amount),
        .item_byte  (item_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .top_byte   (top_byte),
        .stack_empty(stack_empty),
        .status     (status),
        .stacks_used(stacks_used)
    );

    always #5 clk = ~clk;

    // a stack number past the bank acts as empty and of zero capacity
    function automatic bit bank_empty(input int unsigned s);
        return (s >= NUM_STACKS) || (bank_fill[s] == 0);
    endfunction

    function automatic bit bank_full(input int unsigned s);
        return (s >= NUM_STACKS) || (bank_fill[s] >= STACK_DEPTH);
    endfunction

    // apply one word to the predicted bank and return the result it gives
    function automatic bank_result_t apply_to_bank(input msbm_pkg::func_t f,
                                                   input logic [3:0] sa,
                                                   input logic [3:0] sb, input logic [6:0] amt,
                                                   input logic [7:0] b);
        bank_result_t r;
        int unsigned  src;
        int unsigned  dst;
        int unsigned  shown;
        int unsigned  i;
        logic [7:0]   moved;
        bit           halted;
        src    = sa;
        dst    = sb;
        shown  = src;
        halted = 1'b0;
        r.st   = msbm_pkg::ST_OK;
        case (f)
            msbm_pkg::FN_PUSH:
            begin
                push_count++;
                if (bank_full(src))
                begin
                    r.st = msbm_pkg::ST_FULL;
                end
                else
                begin
                    bank_mem[src][bank_fill[src]] = b;
                    bank_fill[src]++;
                    if (src + 1 > bank_used)
                        bank_used = src + 1;
                end
            end
            msbm_pkg::FN_MOVE:
            begin
                // byte by byte: pop the source top, push it on the destination
                move_count++;
                shown = dst;
                for (i = 0; i < amt && !halted; i++)
                begin
                    if (bank_empty(src))
                    begin
                        r.st   = msbm_pkg::ST_EMPTY;
                        halted = 1'b1;
                    end
                    else if (src != dst && bank_full(dst))
                    begin
                        r.st   = msbm_pkg::ST_FULL;
                        halted = 1'b1;
                    end
                    else
                    begin
                        bank_fill[src]--;
                        moved = bank_mem[src][bank_fill[src]];
                        bank_mem[dst][bank_fill[dst]] = moved;
                        bank_fill[dst]++;
                    end
                end
            end
            default:
            begin
                // read top and the unused code leave the bank alone
                read_count++;
            end
        endcase
        if (r.st == msbm_pkg::ST_EMPTY)
            empty_faults++;
        if (r.st == msbm_pkg::ST_FULL)
            full_faults++;
        r.empty = bank_empty(shown);
        r.top   = r.empty ? 8'h00 : bank_mem[shown][bank_fill[shown] - 1];
        r.used  = 5'(bank_used);
        return r;
    endfunction

    // send one word; gaps between bursts drop valid, inside a burst it stays high
    task automatic send_word(input msbm_pkg::func_t f, input logic [3:0] sa,
                             input logic [3:0] sb,
                             input logic [6:0] amt, input logic [7:0] b);
        int gap;
        if (allow_gaps && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        func      = f;
        stack_a   = sa;
        stack_b   = sb;
        amount    = amt;
        item_byte = b;
        in_valid  = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // accepted at this edge: predict now so the bank state stays current
        pending_results.push_back(apply_to_bank(f, sa, sb, amt, b));
        words_sent++;
    endtask

    // mostly a small hot group of stacks so they fill up and overflow
    function automatic logic [3:0] pick_stack();
        if ($urandom_range(0, 3) != 0)
            return 4'(hot_base + $urandom_range(0, 3));
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic send_random_word();
        msbm_pkg::func_t f;
        logic [6:0]      amt;
        int              pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            f = msbm_pkg::FN_PUSH;
        else if (pick < 72)
            f = msbm_pkg::FN_MOVE;
        else if (pick < 92)
            f = msbm_pkg::FN_READ;
        else
            f = msbm_pkg::FN_NONE;
        // small moves dominate, a few go past the stack depth
        pick = $urandom_range(0, 99);
        if (pick < 60)
            amt = 7'($urandom_range(0, 6));
        else if (pick < 85)
            amt = 7'($urandom_range(7, 40));
        else if (pick < 95)
            amt = 7'($urandom_range(41, 64));
        else
            amt = 7'($urandom_range(65, 127));
        send_word(f, pick_stack(), pick_stack(), amt, 8'($urandom));
    endtask

    // every operation on empty and lightly filled stacks, byte extremes
    task automatic test_basic_ops();
        send_word(msbm_pkg::FN_READ, 4'd0, 4'd9, 7'd0, 8'h00);
        send_word(msbm_pkg::FN_NONE, 4'd15, 4'd0, 7'd127, 8'hFF);
        send_word(msbm_pkg::FN_MOVE, 4'd0, 4'd1, 7'd5, 8'h00);    // empty source
        send_word(msbm_pkg::FN_MOVE, 4'd3, 4'd4, 7'd0, 8'h11);    // zero-length move
        send_word(msbm_pkg::FN_PUSH, 4'd0, 4'd0, 7'd0, 8'h00);
        send_word(msbm_pkg::FN_PUSH, 4'd0, 4'd15, 7'd127, 8'hFF);
        send_word(msbm_pkg::FN_PUSH, 4'd15, 4'd0, 7'd0, 8'hA5);   // highest stack, count of 16
        send_word(msbm_pkg::FN_PUSH, 4'd7, 4'd3, 7'd64, 8'h5A);
        send_word(msbm_pkg::FN_READ, 4'd0, 4'd0, 7'd0, 8'h00);
        send_word(msbm_pkg::FN_READ, 4'd15, 4'd15, 7'd127, 8'hFF);
        send_word(msbm_pkg::FN_MOVE, 4'd0, 4'd1, 7'd1, 8'h00);
        send_word(msbm_pkg::FN_MOVE, 4'd1, 4'd1, 7'd3, 8'h00);    // same stack, not empty
        send_word(msbm_pkg::FN_MOVE, 4'd2, 4'd2, 7'd1, 8'h00);    // same stack, empty
        send_word(msbm_pkg::FN_MOVE, 4'd0, 4'd1, 7'd127, 8'h00);  // runs the source dry
        send_word(msbm_pkg::FN_MOVE, 4'd1, 4'd0, 7'd64, 8'h00);
        send_word(msbm_pkg::FN_NONE, 4'd0, 4'd1, 7'd1, 8'h33);
        send_word(msbm_pkg::FN_PUSH, 4'd8, 4'd0, 7'd0, 8'h80);
        send_word(msbm_pkg::FN_PUSH, 4'd8, 4'd0, 7'd0, 8'h01);
        send_word(msbm_pkg::FN_MOVE, 4'd8, 4'd9, 7'd2, 8'h00);    // exact count, reversed order
        send_word(msbm_pkg::FN_READ, 4'd9, 4'd8, 7'd0, 8'h00);
        send_word(msbm_pkg::FN_READ, 4'd8, 4'd9, 7'd0, 8'h00);
    endtask

    // fill one stack to the brim, then overflow it by push and by move
    task automatic test_full_stack();
        int k;
        while (bank_fill[5] < STACK_DEPTH)
            send_word(msbm_pkg::FN_PUSH, 4'd5, 4'($urandom), 7'($urandom), 8'($urandom));
        send_word(msbm_pkg::FN_PUSH, 4'd5, 4'd0, 7'd0, 8'hC3);     // push onto full
        send_word(msbm_pkg::FN_MOVE, 4'd5, 4'd5, 7'd100, 8'h00);   // same stack while full
        for (k = 0; k < 3; k++)
            send_word(msbm_pkg::FN_PUSH, 4'd6, 4'd0, 7'd0, 8'($urandom));
        send_word(msbm_pkg::FN_MOVE, 4'd6, 4'd5, 7'd2, 8'h00);     // full destination at once
        send_word(msbm_pkg::FN_MOVE, 4'd5, 4'd6, 7'd70, 8'h00);    // fills destination midway
        send_word(msbm_pkg::FN_MOVE, 4'd6, 4'd5, 7'd127, 8'h00);
        send_word(msbm_pkg::FN_READ, 4'd5, 4'd0, 7'd0, 8'h00);
        send_word(msbm_pkg::FN_READ, 4'd6, 4'd0, 7'd0, 8'h00);
    endtask

    // random traffic with gaps and stalls, hot group moves every 100 words
    task automatic test_random_traffic(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                hot_base = $urandom_range(0, 12);
            send_random_word();
        end
    endtask

    // back-to-back words with the receiver always ready
    task automatic test_back_to_back(input int count);
        int n;
        allow_gaps = 1'b0;
        rx_always  = 1'b1;
        for (n = 0; n < count; n++)
            send_random_word();
        allow_gaps = 1'b1;
        rx_always  = 1'b0;
    endtask

    // receiver stall pattern, its style picked at random from four
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_style = $urandom_range(0, 3);
        if (rx_always)
            out_ready = 1'b1;
        else
        begin
            case (rx_style)
                0:       out_ready = 1'b1;
                1:       out_ready = ($urandom_range(0, 3) != 0);
                2:       out_ready = ((rx_cycle % 7) >= 2);
                default: out_ready = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // compare every result word with the oldest pending prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing pending: top_byte %0h status %0d",
                       top_byte, status);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (top_byte !== want.top)
                begin
                    $error("top_byte: expected %0h, actual %0h", want.top, top_byte);
                    mismatch_count++;
                end
                if (stack_empty !== want.empty)
                begin
                    $error("stack_empty: expected %0b, actual %0b", want.empty, stack_empty);
                    mismatch_count++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, actual %0d", want.st, status);
                    mismatch_count++;
                end
                if (stacks_used !== want.used)
                begin
                    $error("stacks_used: expected %0d, actual %0d", want.used, stacks_used);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = msbm_pkg::FN_PUSH;
        stack_a   = 4'd0;
        stack_b   = 4'd0;
        amount    = 7'd0;
        item_byte = 8'd0;
        out_ready = 1'b0;
        bank_used = 0;
        foreach (bank_fill[s])
            bank_fill[s] = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_ops();
        test_full_stack();
        test_random_traffic(700);
        test_back_to_back(80);

        // drop valid, drain what is owed, then watch for stray words
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d words (%0d push, %0d move, %0d read or unused) in %0d cycles",
                 words_sent, push_count, move_count, read_count, cycle_count);
        $display("%0d results checked, %0d empty-source and %0d full-stack faults, %0d mismatches",
                 results_seen, empty_faults, full_faults, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
